/* rtl/qenc_pkg.sv */
// ----------------------------------------------------------------------------
// qenc_pkg
// Shared types, register indexes and decode helpers for the rotary
// quadrature encoder with push-button click.
// ----------------------------------------------------------------------------
`default_nettype none

package qenc_pkg;

    // Field widths.
    localparam int unsigned PPS_W   = 4;
    localparam int unsigned RPT_W   = 16;
    localparam int unsigned ACC_W   = 5;
    localparam int unsigned CFG_I_W = 1;
    localparam int unsigned CFG_D_W = 16;

    // Register reset values.
    localparam logic [PPS_W-1:0] PPS_RESET = 4'd4;
    localparam logic [RPT_W-1:0] RPT_RESET = 16'd1000;

    // Configuration register indexes.
    typedef enum logic [CFG_I_W-1:0] {
        CFG_PULSES_PER_STEP    = 1'b0,
        CFG_CLICK_REPEAT_TICKS = 1'b1
    } cfg_idx_t;

    // Event codes carried on event_res.
    typedef enum logic [1:0] {
        EVT_NONE  = 2'd0,
        EVT_CW    = 2'd1,
        EVT_CCW   = 2'd2,
        EVT_ENTER = 2'd3
    } evt_t;

    // One pin sample.
    typedef struct packed {
        logic phase_a;
        logic phase_b;
        logic button_pressed;
    } sample_t;

    // Configuration register set.
    typedef struct packed {
        logic [PPS_W-1:0] pulses_per_step;
        logic [RPT_W-1:0] click_repeat_ticks;
    } cfg_t;

    // One result word.
    typedef struct packed {
        evt_t evt;
        logic move;
    } result_t;

    // Position of a phase code {B, A} in the Gray cycle 00 -> 10 -> 11 -> 01.
    function automatic logic [1:0] phase_pos(input logic [1:0] code);
        logic [1:0] pos;
        unique case (code)
            2'b00:   pos = 2'd0;
            2'b01:   pos = 2'd3;
            2'b10:   pos = 2'd1;
            default: pos = 2'd2;
        endcase
        return pos;
    endfunction

endpackage

`default_nettype wire

/* rtl/qenc_step.sv */
// ----------------------------------------------------------------------------
// qenc_step
// Per-sample decode: phase tracking, pulse accumulation, detent detection and
// the click repeat countdown. Holds the decoder state.
// ----------------------------------------------------------------------------
`default_nettype none

module qenc_step (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             update,
    input  wire qenc_pkg::sample_t sample,
    input  wire qenc_pkg::cfg_t    cfg,
    output qenc_pkg::result_t      result
);

    logic [1:0]                       last_phase_reg;
    logic [1:0]                       last_phase_next;
    logic signed [qenc_pkg::ACC_W-1:0] accum_reg;
    logic signed [qenc_pkg::ACC_W-1:0] accum_next;
    logic [qenc_pkg::RPT_W-1:0]       wait_reg;
    logic [qenc_pkg::RPT_W-1:0]       wait_next;

    logic [1:0]                       code;
    logic [1:0]                       diff;
    logic [qenc_pkg::RPT_W-1:0]       wait_dec;
    logic signed [qenc_pkg::ACC_W-1:0] accum_upd;
    logic [qenc_pkg::ACC_W-1:0]       mag;
    logic [qenc_pkg::PPS_W-1:0]       need;

    assign code = {sample.phase_b, sample.phase_a};
    assign diff = qenc_pkg::phase_pos(code) - qenc_pkg::phase_pos(last_phase_reg);

    // The countdown saturates at zero and runs ahead of the enter check.
    assign wait_dec = (wait_reg != '0) ? wait_reg - qenc_pkg::RPT_W'(1) : wait_reg;

    // Step the accumulator by one for a single Gray move in either direction.
    always_comb
    begin
        accum_upd = accum_reg;
        if (diff == 2'd1)
        begin
            accum_upd = accum_reg + qenc_pkg::ACC_W'(1);
        end
        else if (diff == 2'd3)
        begin
            accum_upd = accum_reg - qenc_pkg::ACC_W'(1);
        end
    end

    assign mag  = accum_upd[qenc_pkg::ACC_W-1] ? (~accum_upd + qenc_pkg::ACC_W'(1))
                                               : accum_upd;
    assign need = (cfg.pulses_per_step == '0) ? qenc_pkg::PPS_W'(1) : cfg.pulses_per_step;

    // Next state and result for this sample.
    always_comb
    begin
        last_phase_next = last_phase_reg;
        accum_next      = accum_reg;
        wait_next       = wait_dec;
        result.evt      = qenc_pkg::EVT_NONE;
        result.move     = 1'b0;
        if (sample.button_pressed)
        begin
            if (wait_dec == '0)
            begin
                result.evt = qenc_pkg::EVT_ENTER;
                wait_next  = cfg.click_repeat_ticks;
            end
        end
        else
        begin
            last_phase_next = code;
            accum_next      = accum_upd;
            if (mag >= {1'b0, need})
            begin
                result.evt  = accum_upd[qenc_pkg::ACC_W-1] ? qenc_pkg::EVT_CCW
                                                            : qenc_pkg::EVT_CW;
                result.move = 1'b1;
                accum_next  = '0;
            end
        end
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_phase_reg <= '0;
            accum_reg      <= '0;
            wait_reg       <= '0;
        end
        else if (update)
        begin
            last_phase_reg <= last_phase_next;
            accum_reg      <= accum_next;
            wait_reg       <= wait_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/quadrature_encoder_with_click.sv */
// ----------------------------------------------------------------------------
// quadrature_encoder_with_click
// Rotary quadrature encoder decoder with push-button enter click.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ------------------------------------------
//  in        in_valid / in_stall    phase_a, phase_b, button_pressed
//  out       out_valid / out_stall  event_res, move_amount
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every sample word yields one result word, passed from the input register
// through the decode stage into the output register.
// A new sample word is accepted every cycle while the output does not stall;
// the rate is set by the single decode stage between the input register and
// the output register. Reset clears the decoder state, loads the register
// defaults and empties both stages. A stalled output holds its word; an empty
// input register still takes one more word before in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_encoder_with_click (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         phase_a,
    input  wire logic                         phase_b,
    input  wire logic                         button_pressed,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [1:0]                        event_res,
    output logic                              move_amount,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [qenc_pkg::CFG_I_W-1:0] cfg_index,
    input  wire logic [qenc_pkg::CFG_D_W-1:0] cfg_data
);

    qenc_pkg::cfg_t    cfg_reg;
    qenc_pkg::sample_t in_word_reg;
    logic              in_valid_reg;
    qenc_pkg::result_t out_word_reg;
    logic              out_valid_reg;
    qenc_pkg::result_t step_result;
    logic              out_en;
    logic              in_en;
    logic              update;

    // Pipeline enables: a stage moves when the one after it can take a word.
    assign out_en   = !out_valid_reg || !out_stall;
    assign in_en    = !in_valid_reg || out_en;
    assign update   = in_valid_reg && out_en;
    assign in_stall = !in_en;

    // Configuration registers, always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulses_per_step    <= qenc_pkg::PPS_RESET;
            cfg_reg.click_repeat_ticks <= qenc_pkg::RPT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (qenc_pkg::cfg_idx_t'(cfg_index))
                qenc_pkg::CFG_PULSES_PER_STEP:
                    cfg_reg.pulses_per_step <= cfg_data[qenc_pkg::PPS_W-1:0];
                qenc_pkg::CFG_CLICK_REPEAT_TICKS:
                    cfg_reg.click_repeat_ticks <= cfg_data[qenc_pkg::RPT_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_en)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_en && in_valid)
        begin
            in_word_reg <= '{phase_a: phase_a, phase_b: phase_b,
                             button_pressed: button_pressed};
        end
    end

    // Decode stage.
    qenc_step u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (update),
        .sample (in_word_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (update)
        begin
            out_word_reg <= step_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_res   = out_word_reg.evt;
    assign move_amount = out_word_reg.move;

endmodule

`default_nettype wire

/* rtl/qenc_checker.sv */
// ----------------------------------------------------------------------------
// qenc_checker
// Port-level checks for the encoder decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module qenc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] event_res,
    input wire logic       move_amount
);

    // A move is reported with a turn event and only then.
    a_move_with_turn: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (move_amount == ((event_res == qenc_pkg::EVT_CW) ||
                                       (event_res == qenc_pkg::EVT_CCW))))
        else $error("move_amount does not match event_res");

    // With the output side empty the input side never stalls.
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

    // A new result word only follows an accepted sample word.
    a_no_spurious_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result word without input");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res) &&
                                   $stable(move_amount))
        else $error("stalled result word changed");

endmodule

bind quadrature_encoder_with_click qenc_checker u_qenc_checker (.*);

`default_nettype wire

/* tb/sv/qenc_event_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qenc_event_checker
// Watches the sample, result and register channels of the encoder decoder.
// It keeps its own copy of the decoder state and the registers, predicts one
// event word for every accepted sample word, and compares each accepted
// result word against the oldest prediction.
// ----------------------------------------------------------------------------

module qenc_event_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         phase_a,
    input  logic                         phase_b,
    input  logic                         button_pressed,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [1:0]                   event_res,
    input  logic                         move_amount,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [qenc_pkg::CFG_I_W-1:0] cfg_index,
    input  logic [qenc_pkg::CFG_D_W-1:0] cfg_data,
    output int                           errors,
    output int                           pending,
    output int                           n_checked,
    output int                           n_turns,
    output int                           n_enters
);

    // Shadow registers and decoder state.
    logic [qenc_pkg::PPS_W-1:0] steps_reg;
    logic [qenc_pkg::RPT_W-1:0] repeat_reg;
    logic [1:0]                 prev_code;
    int                         accum;
    logic [qenc_pkg::RPT_W-1:0] wait_cnt;

    // Predicted event words, oldest first.
    qenc_pkg::result_t expected_events[$];

    int err_cnt;
    int checked_cnt;
    int turn_cnt;
    int enter_cnt;

    // Position of a {B, A} code in the cycle 00 -> 10 -> 11 -> 01.
    function automatic logic [1:0] gray_pos(input logic [1:0] code);
        logic [1:0] pos;
        case (code)
            2'b00:   pos = 2'd0;
            2'b10:   pos = 2'd1;
            2'b11:   pos = 2'd2;
            default: pos = 2'd3;
        endcase
        return pos;
    endfunction

    // Advances the shadow decoder by one tick and returns the event it gives.
    function automatic qenc_pkg::result_t decode_sample(input logic a, input logic b,
                                                       input logic btn);
        qenc_pkg::result_t r;
        logic [1:0]        code;
        logic [1:0]        delta;
        int                need;
        int                mag;
        r.evt  = qenc_pkg::EVT_NONE;
        r.move = 1'b0;
        code   = {b, a};
        // The repeat countdown runs on every tick and stops at zero.
        if (wait_cnt != '0)
            wait_cnt = wait_cnt - qenc_pkg::RPT_W'(1);
        if (btn)
        begin
            // A held button hides the phases entirely.
            if (wait_cnt == '0)
            begin
                r.evt    = qenc_pkg::EVT_ENTER;
                wait_cnt = repeat_reg;
            end
        end
        else
        begin
            if (code != prev_code)
            begin
                // A jump across two positions moves the code but not the count.
                delta = gray_pos(code) - gray_pos(prev_code);
                if (delta == 2'd1)
                    accum = accum + 1;
                else if (delta == 2'd3)
                    accum = accum - 1;
                prev_code = code;
            end
            mag  = (accum < 0) ? -accum : accum;
            need = (steps_reg == '0) ? 1 : int'(steps_reg);
            if (mag >= need)
            begin
                r.evt  = (accum > 0) ? qenc_pkg::EVT_CW : qenc_pkg::EVT_CCW;
                r.move = 1'b1;
                accum  = 0;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        qenc_pkg::result_t exp_word;
        if (!rst_n)
        begin
            steps_reg   = qenc_pkg::PPS_RESET;
            repeat_reg  = qenc_pkg::RPT_RESET;
            prev_code   = 2'b00;
            accum       = 0;
            wait_cnt    = '0;
            expected_events.delete();
            err_cnt     = 0;
            checked_cnt = 0;
            turn_cnt    = 0;
            enter_cnt   = 0;
            errors     <= 0;
            pending    <= 0;
            n_checked  <= 0;
            n_turns    <= 0;
            n_enters   <= 0;
        end
        else
        begin
            // Compare an accepted result word with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: result word with none expected: event %0d move %0d",
                             $time, event_res, move_amount);
                    err_cnt++;
                end
                else
                begin
                    exp_word = expected_events.pop_front();
                    checked_cnt++;
                    if (exp_word.evt == qenc_pkg::EVT_ENTER)
                        enter_cnt++;
                    else if (exp_word.move)
                        turn_cnt++;
                    if (event_res != exp_word.evt)
                    begin
                        $display("%0t: event_res expected %0d actual %0d",
                                 $time, exp_word.evt, event_res);
                        err_cnt++;
                    end
                    if (move_amount != exp_word.move)
                    begin
                        $display("%0t: move_amount expected %0d actual %0d",
                                 $time, exp_word.move, move_amount);
                        err_cnt++;
                    end
                end
            end

            // Track register writes.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == qenc_pkg::CFG_PULSES_PER_STEP)
                    steps_reg = cfg_data[qenc_pkg::PPS_W-1:0];
                else
                    repeat_reg = cfg_data[qenc_pkg::RPT_W-1:0];
            end

            // Predict the word for an accepted sample.
            if (in_valid && !in_stall)
                expected_events.push_back(decode_sample(phase_a, phase_b, button_pressed));

            errors    <= err_cnt;
            pending   <= expected_events.size();
            n_checked <= checked_cnt;
            n_turns   <= turn_cnt;
            n_enters  <= enter_cnt;
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the quadrature encoder decoder with click.
// A directed sequence covers turns in both directions, skipped and repeated
// codes, held buttons and the zero register cases; random phases then run
// bursty turn sequences, button holds and noise under several register
// settings while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------

module tb;

    localparam int IDLE_LIMIT = 2000;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic                         phase_a;
    logic                         phase_b;
    logic                         button_pressed;
    logic                         out_valid;
    logic                         out_stall;
    logic [1:0]                   event_res;
    logic                         move_amount;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic [qenc_pkg::CFG_I_W-1:0] cfg_index;
    logic [qenc_pkg::CFG_D_W-1:0] cfg_data;

    int errors;
    int pending;
    int n_checked;
    int n_turns;
    int n_enters;

    int         burst_left;
    int         samples_sent;
    int         reg_writes;
    int         settings_run;
    int         idle_cycles;
    int         stall_mode;
    int         stall_left;
    logic [1:0] cur_code;

    always #2 clk = ~clk;

    quadrature_encoder_with_click DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .phase_a        (phase_a),
        .phase_b        (phase_b),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .move_amount    (move_amount),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    qenc_event_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .phase_a        (phase_a),
        .phase_b        (phase_b),
        .button_pressed (button_pressed),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .move_amount    (move_amount),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .errors         (errors),
        .pending        (pending),
        .n_checked      (n_checked),
        .n_turns        (n_turns),
        .n_enters       (n_enters)
    );

    // Result side stall pattern: free runs, light random stalls, heavy stalls.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 2) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Watchdog on cycles in which no channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no channel activity for %0d cycles", $time, idle_cycles);
            $display("quadrature_encoder_with_click: mismatch");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Next code one position along the Gray cycle, clockwise or back.
    function automatic logic [1:0] next_code(input logic [1:0] code, input logic cw);
        logic [1:0] nxt;
        case (code)
            2'b00:   nxt = cw ? 2'b10 : 2'b01;
            2'b10:   nxt = cw ? 2'b11 : 2'b00;
            2'b11:   nxt = cw ? 2'b01 : 2'b10;
            default: nxt = cw ? 2'b00 : 2'b11;
        endcase
        return nxt;
    endfunction

    // Sends one sample word; bursts of random length with random gaps.
    task automatic send_sample(input logic a, input logic b, input logic btn);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        phase_a        <= a;
        phase_b        <= b;
        button_pressed <= btn;
        burst_left--;
        do
            @(posedge clk);
        while (in_stall);
        samples_sent++;
    endtask

    // Sends the current code with the button released.
    task automatic send_code(input logic [1:0] code);
        cur_code = code;
        send_sample(code[0], code[1], 1'b0);
    endtask

    // Stops sending and waits until every predicted word has arrived.
    task automatic drain_results();
        @(negedge clk);
        in_valid  <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic write_reg(input qenc_pkg::cfg_idx_t idx,
                             input logic [qenc_pkg::CFG_D_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        reg_writes++;
    endtask

    // Loads both registers once the block is idle.
    task automatic load_settings(input logic [qenc_pkg::PPS_W-1:0] steps,
                                 input logic [qenc_pkg::RPT_W-1:0] rpt);
        drain_results();
        write_reg(qenc_pkg::CFG_PULSES_PER_STEP,
                  {{(qenc_pkg::CFG_D_W-qenc_pkg::PPS_W){1'b0}}, steps});
        write_reg(qenc_pkg::CFG_CLICK_REPEAT_TICKS, rpt);
        settings_run++;
    endtask

    // Random phase: mostly clean turn runs, with holds, skips, dwells and noise.
    task automatic run_random(input int count, input bit pause_midway);
        int          start;
        int          len;
        int          kind;
        bit          paused;
        logic        dir;
        logic [31:0] rnd;
        start  = samples_sent;
        paused = 1'b0;
        while (samples_sent - start < count)
        begin
            if (pause_midway && !paused && (samples_sent - start >= count / 2))
            begin
                drain_results();
                paused = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                // Turn run with an occasional jitter back.
                dir = 1'($urandom_range(0, 1));
                len = $urandom_range(1, 20);
                repeat (len)
                begin
                    if ($urandom_range(0, 9) == 0)
                        send_code(next_code(cur_code, !dir));
                    else
                        send_code(next_code(cur_code, dir));
                end
            end
            else if (kind < 70)
            begin
                // Button hold; the phases wander but are ignored.
                len = $urandom_range(1, 12);
                repeat (len)
                begin
                    rnd = $urandom;
                    send_sample(rnd[0], rnd[1], 1'b1);
                end
            end
            else if (kind < 80)
                send_code(cur_code ^ 2'b11);
            else if (kind < 90)
            begin
                len = $urandom_range(1, 4);
                repeat (len) send_code(cur_code);
            end
            else
            begin
                rnd = $urandom;
                if (rnd[2])
                    send_sample(rnd[0], rnd[1], 1'b1);
                else
                    send_code(rnd[1:0]);
            end
        end
    endtask

    initial
    begin
        int                         k;
        logic [qenc_pkg::PPS_W-1:0] steps;
        logic [qenc_pkg::RPT_W-1:0] rpt;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        phase_a        = 1'b0;
        phase_b        = 1'b0;
        button_pressed = 1'b0;
        out_stall      = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = qenc_pkg::CFG_PULSES_PER_STEP;
        cfg_data       = '0;
        burst_left     = 0;
        samples_sent   = 0;
        reg_writes     = 0;
        settings_run   = 1;
        idle_cycles    = 0;
        stall_mode     = 0;
        stall_left     = 0;
        cur_code       = 2'b00;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: four codes per step, clockwise then back.
        send_code(2'b10);
        send_code(2'b11);
        send_code(2'b01);
        send_code(2'b00);
        send_code(2'b01);
        send_code(2'b11);
        send_code(2'b10);
        send_code(2'b00);
        // Skipped codes, a repeated code and a half step undone.
        send_code(2'b11);
        send_code(2'b00);
        send_code(2'b00);
        send_code(2'b10);
        send_code(2'b00);

        // Steps register zero acts as one; repeat register zero clicks every tick.
        load_settings(4'd0, 16'd0);
        send_code(2'b10);
        send_code(2'b00);
        send_sample(1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1);
        send_code(2'b00);
        send_code(2'b01);
        send_code(2'b00);

        // Random phases over a spread of settings, the longest repeat last.
        load_settings(4'd1, 16'd1);
        run_random(50, 1'b0);
        load_settings(4'd2, 16'd3);
        run_random(60, 1'b1);
        load_settings(4'd0, 16'd0);
        run_random(40, 1'b0);
        for (k = 0; k < 3; k++)
        begin
            steps = qenc_pkg::PPS_W'($urandom_range(1, 8));
            rpt   = ($urandom_range(0, 3) == 0) ?
                    qenc_pkg::RPT_W'($urandom_range(13, 200)) :
                    qenc_pkg::RPT_W'($urandom_range(1, 12));
            load_settings(steps, rpt);
            run_random(50, 1'b0);
        end
        load_settings(4'd8, 16'd65535);
        run_random(60, 1'b0);

        // Let any stray word show up after the last prediction is met.
        drain_results();
        repeat (10) @(posedge clk);

        $display("Summary: %0d sample words under %0d register settings, %0d register writes.",
                 samples_sent, settings_run, reg_writes);
        $display("Summary: %0d result words checked, %0d steps and %0d enter clicks among them.",
                 n_checked, n_turns, n_enters);
        if (pending != 0)
            $display("%0t: %0d predicted words never arrived", $time, pending);
        if (errors == 0 && pending == 0)
            $display("quadrature_encoder_with_click: match");
        else
            $display("quadrature_encoder_with_click: mismatch");
        $finish;
    end

endmodule
